@@ rtl/gcs_pkg.sv @@
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types, constants and helpers of the gap crossing sequencer.
// ----------------------------------------------------------------------------
package gcs_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned DIST_BITS_DEF = 12;

  // Configuration register widths
  localparam int unsigned LEVEL_W  = 10;
  localparam int unsigned THRESH_W = 12;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned TICKS_W  = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1000;

  // Result field widths and packed layout
  localparam int unsigned LIFT_W   = 11;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned PHASE_W  = 4;
  localparam int unsigned OUT_DRIVE_LSB  = 0;
  localparam int unsigned OUT_LIFT_LSB   = OUT_DRIVE_LSB + LEVEL_W;
  localparam int unsigned OUT_START_BIT  = OUT_LIFT_LSB + LIFT_W;
  localparam int unsigned OUT_AMOUNT_LSB = OUT_START_BIT + 1;
  localparam int unsigned OUT_PHASE_LSB  = OUT_AMOUNT_LSB + AMOUNT_W;
  localparam int unsigned OUT_BITS       = OUT_PHASE_LSB + PHASE_W;
  localparam int unsigned OUT_W          = ((OUT_BITS + 7) / 8) * 8;

  // Reset values of the configuration registers
  localparam logic [LEVEL_W-1:0]  DRIVE_SPEED_RST = 10'd400;
  localparam logic [THRESH_W-1:0] GAP_THRESH_RST  = 12'd250;
  localparam logic [LEVEL_W-1:0]  LIFT_POWER_RST  = 10'd900;
  localparam logic [MS_W-1:0]     ALIGN_MS_RST    = 16'd500;
  localparam logic [MS_W-1:0]     LOWER_MS_RST    = 16'd3000;
  localparam logic [MS_W-1:0]     RAISE_MS_RST    = 16'd2500;
  localparam logic [MS_W-1:0]     SETTLE_MS_RST   = 16'd500;
  localparam logic [TICKS_W-1:0]  MOVE_TICKS_RST  = 15'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_SPEED = 3'd0,
    REG_GAP_THRESH  = 3'd1,
    REG_LIFT_POWER  = 3'd2,
    REG_ALIGN_MS    = 3'd3,
    REG_LOWER_MS    = 3'd4,
    REG_RAISE_MS    = 3'd5,
    REG_SETTLE_MS   = 3'd6,
    REG_MOVE_TICKS  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]  drive_speed;
    logic [THRESH_W-1:0] gap_threshold;
    logic [LEVEL_W-1:0]  lift_power;
    logic [MS_W-1:0]     align_stable_ms;
    logic [MS_W-1:0]     lower_time_ms;
    logic [MS_W-1:0]     raise_time_ms;
    logic [MS_W-1:0]     settle_time_ms;
    logic [TICKS_W-1:0]  move_ticks;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]         phase;
    logic signed [AMOUNT_W-1:0] move_amount;
    logic                       move_start;
    logic signed [LIFT_W-1:0]   lift_drive;
    logic [LEVEL_W-1:0]         drive_power;
  } result_t;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_RELEASE = 9'b000000010,
    PH_SEARCH  = 9'b000000100,
    PH_ALIGN   = 9'b000001000,
    PH_LOWER   = 9'b000010000,
    PH_ACROSS  = 9'b000100000,
    PH_SETTLE  = 9'b001000000,
    PH_RAISE   = 9'b010000000,
    PH_AHEAD   = 9'b100000000
  } phase_e;

  localparam logic [PHASE_W-1:0] CODE_IDLE    = 4'd0;
  localparam logic [PHASE_W-1:0] CODE_RELEASE = 4'd1;
  localparam logic [PHASE_W-1:0] CODE_SEARCH  = 4'd2;
  localparam logic [PHASE_W-1:0] CODE_ALIGN   = 4'd3;
  localparam logic [PHASE_W-1:0] CODE_LOWER   = 4'd4;
  localparam logic [PHASE_W-1:0] CODE_ACROSS  = 4'd5;
  localparam logic [PHASE_W-1:0] CODE_SETTLE  = 4'd6;
  localparam logic [PHASE_W-1:0] CODE_RAISE   = 4'd7;
  localparam logic [PHASE_W-1:0] CODE_AHEAD   = 4'd8;

  function automatic logic [PHASE_W-1:0] phase_code(phase_e ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_IDLE:    code = CODE_IDLE;
      PH_RELEASE: code = CODE_RELEASE;
      PH_SEARCH:  code = CODE_SEARCH;
      PH_ALIGN:   code = CODE_ALIGN;
      PH_LOWER:   code = CODE_LOWER;
      PH_ACROSS:  code = CODE_ACROSS;
      PH_SETTLE:  code = CODE_SETTLE;
      PH_RAISE:   code = CODE_RAISE;
      PH_AHEAD:   code = CODE_AHEAD;
      default:    code = CODE_IDLE;
    endcase
    return code;
  endfunction

  function automatic logic [LEVEL_W-1:0] clamp_level(logic [LEVEL_W-1:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

endpackage

@@ rtl/gcs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// gcs_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module gcs_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output gcs_pkg::cfg_t                   cfg_o
);

  gcs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (gcs_pkg::reg_idx_e'(cfg_index_i))
        gcs_pkg::REG_DRIVE_SPEED: cfg_d.drive_speed     = cfg_data_i[gcs_pkg::LEVEL_W-1:0];
        gcs_pkg::REG_GAP_THRESH:  cfg_d.gap_threshold   = cfg_data_i[gcs_pkg::THRESH_W-1:0];
        gcs_pkg::REG_LIFT_POWER:  cfg_d.lift_power      = cfg_data_i[gcs_pkg::LEVEL_W-1:0];
        gcs_pkg::REG_ALIGN_MS:    cfg_d.align_stable_ms = cfg_data_i[gcs_pkg::MS_W-1:0];
        gcs_pkg::REG_LOWER_MS:    cfg_d.lower_time_ms   = cfg_data_i[gcs_pkg::MS_W-1:0];
        gcs_pkg::REG_RAISE_MS:    cfg_d.raise_time_ms   = cfg_data_i[gcs_pkg::MS_W-1:0];
        gcs_pkg::REG_SETTLE_MS:   cfg_d.settle_time_ms  = cfg_data_i[gcs_pkg::MS_W-1:0];
        gcs_pkg::REG_MOVE_TICKS:  cfg_d.move_ticks      = cfg_data_i[gcs_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_speed     <= gcs_pkg::DRIVE_SPEED_RST;
      cfg_q.gap_threshold   <= gcs_pkg::GAP_THRESH_RST;
      cfg_q.lift_power      <= gcs_pkg::LIFT_POWER_RST;
      cfg_q.align_stable_ms <= gcs_pkg::ALIGN_MS_RST;
      cfg_q.lower_time_ms   <= gcs_pkg::LOWER_MS_RST;
      cfg_q.raise_time_ms   <= gcs_pkg::RAISE_MS_RST;
      cfg_q.settle_time_ms  <= gcs_pkg::SETTLE_MS_RST;
      cfg_q.move_ticks      <= gcs_pkg::MOVE_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/gcs_core.sv @@
// ----------------------------------------------------------------------------
// gcs_core
// Phase sequencer: gap detection, timers and move handshake for one tick.
// ----------------------------------------------------------------------------
module gcs_core #(
  parameter int unsigned TIME_BITS = gcs_pkg::TIME_BITS_DEF,
  parameter int unsigned DIST_BITS = gcs_pkg::DIST_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  gcs_pkg::cfg_t         cfg_i,
  input  logic [DIST_BITS-1:0]  dist_bridge_end_i,
  input  logic [DIST_BITS-1:0]  dist_robot_rear_i,
  input  logic [DIST_BITS-1:0]  dist_robot_front_i,
  input  logic [DIST_BITS-1:0]  dist_bridge_start_i,
  input  logic                  button_pressed_i,
  input  logic                  move_done_i,
  input  logic [TIME_BITS-1:0]  time_ms_i,
  output gcs_pkg::result_t      result_o
);

  localparam int unsigned CMP_W =
    (DIST_BITS > gcs_pkg::THRESH_W) ? DIST_BITS : gcs_pkg::THRESH_W;

  gcs_pkg::phase_e      phase_q, phase_d;
  logic [TIME_BITS-1:0] entry_q, entry_d;
  logic [TIME_BITS-1:0] align_start_q, align_start_d;
  logic                 align_valid_q, align_valid_d;
  logic                 move_issued_q, move_issued_d;

  logic gap_end, gap_rear, gap_front, gap_start;
  logic [CMP_W-1:0] thresh;
  logic [TIME_BITS-1:0] since_entry, since_align;
  logic [gcs_pkg::LEVEL_W-1:0] lift_mag, drive_lvl;
  logic signed [gcs_pkg::LIFT_W-1:0] lift_pos;
  logic signed [gcs_pkg::AMOUNT_W-1:0] ticks_pos;
  gcs_pkg::result_t res;

  assign thresh = CMP_W'(cfg_i.gap_threshold);
  assign gap_end   = (dist_bridge_end_i == '0)   || (CMP_W'(dist_bridge_end_i) > thresh);
  assign gap_rear  = (dist_robot_rear_i == '0)   || (CMP_W'(dist_robot_rear_i) > thresh);
  assign gap_front = (dist_robot_front_i == '0)  || (CMP_W'(dist_robot_front_i) > thresh);
  assign gap_start = (dist_bridge_start_i == '0) || (CMP_W'(dist_bridge_start_i) > thresh);

  // Differences wrap at the timestamp width
  assign since_entry = time_ms_i - entry_q;
  assign since_align = time_ms_i - align_start_q;

  assign lift_mag  = gcs_pkg::clamp_level(cfg_i.lift_power);
  assign drive_lvl = gcs_pkg::clamp_level(cfg_i.drive_speed);
  assign lift_pos  = $signed({1'b0, lift_mag});
  assign ticks_pos = $signed({1'b0, cfg_i.move_ticks});

  always_comb begin
    phase_d       = phase_q;
    entry_d       = entry_q;
    align_start_d = align_start_q;
    align_valid_d = align_valid_q;
    move_issued_d = move_issued_q;
    res           = '0;
    unique case (phase_q)
      gcs_pkg::PH_IDLE: begin
        if (button_pressed_i) begin
          phase_d = gcs_pkg::PH_RELEASE;
          entry_d = time_ms_i;
        end
      end
      gcs_pkg::PH_RELEASE: begin
        if (!button_pressed_i) phase_d = gcs_pkg::PH_SEARCH;
      end
      gcs_pkg::PH_SEARCH: begin
        if (gap_front) begin
          phase_d       = gcs_pkg::PH_ALIGN;
          entry_d       = time_ms_i;
          align_valid_d = 1'b0;
        end else begin
          res.drive_power = drive_lvl;
        end
      end
      gcs_pkg::PH_ALIGN: begin
        if (!gap_end && !gap_start) begin
          if (!align_valid_q) begin
            align_valid_d = 1'b1;
            align_start_d = time_ms_i;
          end else if (since_align >= TIME_BITS'(cfg_i.align_stable_ms)) begin
            phase_d = gcs_pkg::PH_LOWER;
            entry_d = time_ms_i;
          end
        end else begin
          align_valid_d = 1'b0;
        end
      end
      gcs_pkg::PH_LOWER: begin
        if (since_entry >= TIME_BITS'(cfg_i.lower_time_ms)) begin
          phase_d       = gcs_pkg::PH_ACROSS;
          entry_d       = time_ms_i;
          move_issued_d = 1'b0;
        end else begin
          res.lift_drive = -lift_pos;
        end
      end
      gcs_pkg::PH_ACROSS: begin
        // a move_done on the issuing tick does not count
        if (!move_issued_q) begin
          move_issued_d   = 1'b1;
          res.move_start  = 1'b1;
          res.move_amount = ticks_pos;
        end else if (move_done_i) begin
          phase_d = gcs_pkg::PH_SETTLE;
          entry_d = time_ms_i;
        end
      end
      gcs_pkg::PH_SETTLE: begin
        if (since_entry >= TIME_BITS'(cfg_i.settle_time_ms) && !gap_rear && !gap_front) begin
          phase_d = gcs_pkg::PH_RAISE;
          entry_d = time_ms_i;
        end
      end
      gcs_pkg::PH_RAISE: begin
        if (since_entry >= TIME_BITS'(cfg_i.raise_time_ms)) begin
          phase_d       = gcs_pkg::PH_AHEAD;
          entry_d       = time_ms_i;
          move_issued_d = 1'b0;
        end else begin
          res.lift_drive = lift_pos;
        end
      end
      gcs_pkg::PH_AHEAD: begin
        if (!move_issued_q) begin
          move_issued_d   = 1'b1;
          res.move_start  = 1'b1;
          res.move_amount = -ticks_pos;
        end else if (move_done_i) begin
          phase_d       = gcs_pkg::PH_SEARCH;
          entry_d       = time_ms_i;
          align_valid_d = 1'b0;
        end
      end
      default: phase_d = gcs_pkg::PH_IDLE;
    endcase
    res.phase = gcs_pkg::phase_code(phase_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= gcs_pkg::PH_IDLE;
      entry_q       <= '0;
      align_start_q <= '0;
      align_valid_q <= 1'b0;
      move_issued_q <= 1'b0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      entry_q       <= entry_d;
      align_start_q <= align_start_d;
      align_valid_q <= align_valid_d;
      move_issued_q <= move_issued_d;
    end
  end

  assign result_o = res;

endmodule

@@ rtl/gap_crossing_sequencer.sv @@
// ----------------------------------------------------------------------------
// gap_crossing_sequencer
// Robot gap crossing sequencer, one control tick in, one command set out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one control tick per transaction: four distance readings,
//   the start button level, the move-finished flag and a millisecond stamp.
//   m_axis returns one result per tick: drive power, signed lift drive, move
//   start pulse with its signed amount, and the phase after the tick.
//   The cfg channel writes one configuration register per transaction and
//   is always ready; write it only while no tick is in flight.
//   Processing: a taken tick waits in the input register until the result
//   register is free; the sequencer then steps on it, and its result is
//   captured in the result register and offered on m_axis.
//   Throughput: one tick per cycle while m_axis is not stalled, set by the
//   single input register feeding the sequencer and the result register.
//   A stalled m_axis holds its result; one more tick waits in the input
//   register, after which s_axis_tready drops until the receiver takes data.
//   Reset puts the sequencer in idle, empties both registers and loads the
//   default configuration.
// ----------------------------------------------------------------------------
module gap_crossing_sequencer #(
  parameter int unsigned TIME_BITS = gcs_pkg::TIME_BITS_DEF,
  parameter int unsigned DIST_BITS = gcs_pkg::DIST_BITS_DEF,
  localparam int unsigned IN_BITS  = 4 * DIST_BITS + 2 + TIME_BITS,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // dist_bridge_end, dist_robot_rear, dist_robot_front, dist_bridge_start,
  // button_pressed, move_done, time_ms (lowest bits first), zero padded
  input  logic [IN_W-1:0]                 s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // drive_power, lift_drive, move_start, move_amount, phase (lowest first)
  output logic [gcs_pkg::OUT_W-1:0]       m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned BTN_BIT  = 4 * DIST_BITS;
  localparam int unsigned DONE_BIT = BTN_BIT + 1;
  localparam int unsigned TIME_LSB = DONE_BIT + 1;

  gcs_pkg::cfg_t    cfg;
  gcs_pkg::result_t result;

  logic                 in_valid_q;
  logic [IN_BITS-1:0]   in_data_q;
  logic                 out_valid_q;
  logic [gcs_pkg::OUT_W-1:0] out_data_q;
  logic                 out_free, step, in_take;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  gcs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gcs_core #(
    .TIME_BITS (TIME_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .step_i              (step),
    .cfg_i               (cfg),
    .dist_bridge_end_i   (in_data_q[0*DIST_BITS +: DIST_BITS]),
    .dist_robot_rear_i   (in_data_q[1*DIST_BITS +: DIST_BITS]),
    .dist_robot_front_i  (in_data_q[2*DIST_BITS +: DIST_BITS]),
    .dist_bridge_start_i (in_data_q[3*DIST_BITS +: DIST_BITS]),
    .button_pressed_i    (in_data_q[BTN_BIT]),
    .move_done_i         (in_data_q[DONE_BIT]),
    .time_ms_i           (in_data_q[TIME_LSB +: TIME_BITS]),
    .result_o            (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata[IN_BITS-1:0];
    end
    if (step) begin
      out_data_q <= gcs_pkg::OUT_W'(result);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/gcs_checker.sv @@
// ----------------------------------------------------------------------------
// gcs_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module gcs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [gcs_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic [gcs_pkg::LEVEL_W-1:0]  drive;
  logic [gcs_pkg::LIFT_W-1:0]   lift;
  logic                         mstart;
  logic [gcs_pkg::AMOUNT_W-1:0] amount;
  logic [gcs_pkg::PHASE_W-1:0]  phase;

  assign drive  = m_axis_tdata[gcs_pkg::OUT_DRIVE_LSB +: gcs_pkg::LEVEL_W];
  assign lift   = m_axis_tdata[gcs_pkg::OUT_LIFT_LSB +: gcs_pkg::LIFT_W];
  assign mstart = m_axis_tdata[gcs_pkg::OUT_START_BIT];
  assign amount = m_axis_tdata[gcs_pkg::OUT_AMOUNT_LSB +: gcs_pkg::AMOUNT_W];
  assign phase  = m_axis_tdata[gcs_pkg::OUT_PHASE_LSB +: gcs_pkg::PHASE_W];

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a move is only started while crossing or moving the bridge ahead
  a_move_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mstart |->
      phase == gcs_pkg::CODE_ACROSS || phase == gcs_pkg::CODE_AHEAD)
    else $error("move started outside a move phase");

  a_amount_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !mstart |-> amount == '0)
    else $error("move amount without move start");

  // drive only in search, never above the level limit
  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && drive != '0 |->
      phase == gcs_pkg::CODE_SEARCH && drive <= gcs_pkg::LEVEL_MAX)
    else $error("drive power outside search or above limit");

  a_lift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && lift != '0 |->
      phase == gcs_pkg::CODE_LOWER || phase == gcs_pkg::CODE_RAISE)
    else $error("lift driven outside a lift phase");

endmodule

bind gap_crossing_sequencer gcs_checker u_gcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ verif/gap_crossing_sequencer_checker.sv @@
// ----------------------------------------------------------------------------
// gap_crossing_sequencer_checker
// Watches the tick, command and register channels of the gap crossing
// sequencer. It runs its own copy of the crossing sequence on every accepted
// tick and compares each returned command set, field by field, against the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gap_crossing_sequencer_checker #(
  parameter int unsigned TICK_W = 88
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  input  logic                            s_ready_i,
  input  logic [TICK_W-1:0]               s_data_i,
  input  logic                            m_valid_i,
  input  logic                            m_ready_i,
  input  logic [gcs_pkg::OUT_W-1:0]       m_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                              fail_count_o,
  output int                              in_flight_o,
  output logic [gcs_pkg::PHASE_W-1:0]     phase_o
);

  localparam int unsigned RES_W = gcs_pkg::OUT_W;

  localparam gcs_pkg::cfg_t CFG_DEFAULTS = '{
    drive_speed:     gcs_pkg::DRIVE_SPEED_RST,
    gap_threshold:   gcs_pkg::GAP_THRESH_RST,
    lift_power:      gcs_pkg::LIFT_POWER_RST,
    align_stable_ms: gcs_pkg::ALIGN_MS_RST,
    lower_time_ms:   gcs_pkg::LOWER_MS_RST,
    raise_time_ms:   gcs_pkg::RAISE_MS_RST,
    settle_time_ms:  gcs_pkg::SETTLE_MS_RST,
    move_ticks:      gcs_pkg::MOVE_TICKS_RST
  };

  gcs_pkg::cfg_t               cfg_q;
  logic [gcs_pkg::PHASE_W-1:0] phase_q;
  logic [31:0]                 entry_q;
  logic [31:0]                 align_start_q;
  logic                        align_valid_q;
  logic                        move_issued_q;

  gcs_pkg::result_t   awaited_cmds[$];
  int unsigned        cmd_no;
  int                 fails;

  task automatic report_mismatch(input string what, input logic [RES_W-1:0] got,
                                 input logic [RES_W-1:0] want);
    $display("%0t: command %0d %s: got %h, want %h", $time, cmd_no, what, got, want);
    fails++;
  endtask

  function automatic logic sees_gap(logic [gcs_pkg::DIST_BITS_DEF-1:0] reading);
    return (reading == '0) || (reading > cfg_q.gap_threshold);
  endfunction

  // Run one control tick through the sequence and return the commands it yields
  function automatic gcs_pkg::result_t advance_sequence(logic [TICK_W-1:0] raw);
    logic [11:0]                 d_end, d_rear, d_front, d_start;
    logic                        btn, done;
    logic [31:0]                 now, since_entry, since_align;
    logic [gcs_pkg::LEVEL_W-1:0] drive_lvl, lift_lvl;
    gcs_pkg::result_t            cmd;
    d_end   = raw[11:0];
    d_rear  = raw[23:12];
    d_front = raw[35:24];
    d_start = raw[47:36];
    btn     = raw[48];
    done    = raw[49];
    now     = raw[81:50];
    since_entry = now - entry_q;
    since_align = now - align_start_q;
    drive_lvl = (cfg_q.drive_speed > gcs_pkg::LEVEL_MAX) ? gcs_pkg::LEVEL_MAX
                                                         : cfg_q.drive_speed;
    lift_lvl  = (cfg_q.lift_power > gcs_pkg::LEVEL_MAX) ? gcs_pkg::LEVEL_MAX
                                                        : cfg_q.lift_power;
    cmd = '0;
    case (phase_q)
      gcs_pkg::CODE_IDLE: begin
        if (btn) begin
          phase_q = gcs_pkg::CODE_RELEASE;
          entry_q = now;
        end
      end
      gcs_pkg::CODE_RELEASE: begin
        if (!btn) phase_q = gcs_pkg::CODE_SEARCH;
      end
      gcs_pkg::CODE_SEARCH: begin
        if (sees_gap(d_front)) begin
          phase_q       = gcs_pkg::CODE_ALIGN;
          entry_q       = now;
          align_valid_q = 1'b0;
        end else begin
          cmd.drive_power = drive_lvl;
        end
      end
      gcs_pkg::CODE_ALIGN: begin
        if (!sees_gap(d_end) && !sees_gap(d_start)) begin
          if (!align_valid_q) begin
            align_valid_q = 1'b1;
            align_start_q = now;
          end else if (since_align >= 32'(cfg_q.align_stable_ms)) begin
            phase_q = gcs_pkg::CODE_LOWER;
            entry_q = now;
          end
        end else begin
          align_valid_q = 1'b0;
        end
      end
      gcs_pkg::CODE_LOWER: begin
        if (since_entry >= 32'(cfg_q.lower_time_ms)) begin
          phase_q       = gcs_pkg::CODE_ACROSS;
          entry_q       = now;
          move_issued_q = 1'b0;
        end else begin
          cmd.lift_drive = -$signed({1'b0, lift_lvl});
        end
      end
      gcs_pkg::CODE_ACROSS: begin
        // a done flag on the issuing tick belongs to an older move: drop it
        if (!move_issued_q) begin
          move_issued_q   = 1'b1;
          cmd.move_start  = 1'b1;
          cmd.move_amount = {1'b0, cfg_q.move_ticks};
        end else if (done) begin
          phase_q = gcs_pkg::CODE_SETTLE;
          entry_q = now;
        end
      end
      gcs_pkg::CODE_SETTLE: begin
        if (since_entry >= 32'(cfg_q.settle_time_ms) && !sees_gap(d_rear) &&
            !sees_gap(d_front)) begin
          phase_q = gcs_pkg::CODE_RAISE;
          entry_q = now;
        end
      end
      gcs_pkg::CODE_RAISE: begin
        if (since_entry >= 32'(cfg_q.raise_time_ms)) begin
          phase_q       = gcs_pkg::CODE_AHEAD;
          entry_q       = now;
          move_issued_q = 1'b0;
        end else begin
          cmd.lift_drive = $signed({1'b0, lift_lvl});
        end
      end
      gcs_pkg::CODE_AHEAD: begin
        if (!move_issued_q) begin
          move_issued_q   = 1'b1;
          cmd.move_start  = 1'b1;
          cmd.move_amount = -$signed({1'b0, cfg_q.move_ticks});
        end else if (done) begin
          phase_q       = gcs_pkg::CODE_SEARCH;
          entry_q       = now;
          align_valid_q = 1'b0;
        end
      end
      default: phase_q = gcs_pkg::CODE_IDLE;
    endcase
    cmd.phase = phase_q;
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gcs_pkg::result_t got, want;
    if (!rst_ni) begin
      cfg_q         = CFG_DEFAULTS;
      phase_q       = gcs_pkg::CODE_IDLE;
      entry_q       = '0;
      align_start_q = '0;
      align_valid_q = 1'b0;
      move_issued_q = 1'b0;
      awaited_cmds.delete();
      cmd_no        = 0;
      fails         = 0;
      fail_count_o <= 0;
      in_flight_o  <= 0;
      phase_o      <= gcs_pkg::CODE_IDLE;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (gcs_pkg::reg_idx_e'(cfg_index_i))
          gcs_pkg::REG_DRIVE_SPEED:
            cfg_q.drive_speed     = cfg_data_i[gcs_pkg::LEVEL_W-1:0];
          gcs_pkg::REG_GAP_THRESH:
            cfg_q.gap_threshold   = cfg_data_i[gcs_pkg::THRESH_W-1:0];
          gcs_pkg::REG_LIFT_POWER:
            cfg_q.lift_power      = cfg_data_i[gcs_pkg::LEVEL_W-1:0];
          gcs_pkg::REG_ALIGN_MS:
            cfg_q.align_stable_ms = cfg_data_i[gcs_pkg::MS_W-1:0];
          gcs_pkg::REG_LOWER_MS:
            cfg_q.lower_time_ms   = cfg_data_i[gcs_pkg::MS_W-1:0];
          gcs_pkg::REG_RAISE_MS:
            cfg_q.raise_time_ms   = cfg_data_i[gcs_pkg::MS_W-1:0];
          gcs_pkg::REG_SETTLE_MS:
            cfg_q.settle_time_ms  = cfg_data_i[gcs_pkg::MS_W-1:0];
          gcs_pkg::REG_MOVE_TICKS:
            cfg_q.move_ticks      = cfg_data_i[gcs_pkg::TICKS_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting: a command never leaves on its own tick's edge
      if (m_valid_i && m_ready_i) begin
        got = gcs_pkg::result_t'(m_data_i[gcs_pkg::OUT_BITS-1:0]);
        cmd_no++;
        if (awaited_cmds.size() == 0) begin
          report_mismatch("arrived with no tick waiting", m_data_i, '0);
        end else begin
          want = awaited_cmds.pop_front();
          if (got.drive_power !== want.drive_power)
            report_mismatch("drive_power", RES_W'(got.drive_power),
                            RES_W'(want.drive_power));
          if (got.lift_drive !== want.lift_drive)
            report_mismatch("lift_drive", RES_W'(got.lift_drive),
                            RES_W'(want.lift_drive));
          if (got.move_start !== want.move_start)
            report_mismatch("move_start", RES_W'(got.move_start),
                            RES_W'(want.move_start));
          if (got.move_amount !== want.move_amount)
            report_mismatch("move_amount", RES_W'(got.move_amount),
                            RES_W'(want.move_amount));
          if (got.phase !== want.phase)
            report_mismatch("phase", RES_W'(got.phase), RES_W'(want.phase));
        end
      end
      if (s_valid_i && s_ready_i)
        awaited_cmds.push_back(advance_sequence(s_data_i));
      fail_count_o <= fails;
      in_flight_o  <= awaited_cmds.size();
      phase_o      <= phase_q;
    end
  end

endmodule

@@ verif/gap_crossing_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// gap_crossing_sequencer_tb
// Drives control ticks into the gap crossing sequencer: a directed walk
// through one full crossing with its boundary cases, then biased random ticks
// under several register settings, extremes included. Both streams idle and
// stall at random. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gap_crossing_sequencer_tb;

  localparam int unsigned TICK_BITS     =
    4 * gcs_pkg::DIST_BITS_DEF + 2 + gcs_pkg::TIME_BITS_DEF;
  localparam int unsigned TICK_W        = ((TICK_BITS + 7) / 8) * 8;
  localparam int unsigned SETS          = 6;
  localparam int unsigned TICKS_PER_SET = 255;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [31:0] NEAR_WRAP     = 32'hFFFF_FE00;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [TICK_W-1:0]              s_axis_tdata  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [gcs_pkg::OUT_W-1:0]      m_axis_tdata;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [gcs_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [gcs_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  int                             fail_count;
  int                             in_flight;
  logic [gcs_pkg::PHASE_W-1:0]    seq_phase;

  gcs_pkg::cfg_t cfg_mirror = '{
    drive_speed:     gcs_pkg::DRIVE_SPEED_RST,
    gap_threshold:   gcs_pkg::GAP_THRESH_RST,
    lift_power:      gcs_pkg::LIFT_POWER_RST,
    align_stable_ms: gcs_pkg::ALIGN_MS_RST,
    lower_time_ms:   gcs_pkg::LOWER_MS_RST,
    raise_time_ms:   gcs_pkg::RAISE_MS_RST,
    settle_time_ms:  gcs_pkg::SETTLE_MS_RST,
    move_ticks:      gcs_pkg::MOVE_TICKS_RST
  };

  logic [31:0] now_ms      = '0;
  logic        tx_burst    = 1'b0;
  logic        rx_burst    = 1'b0;
  int unsigned ticks_sent  = 0;
  int unsigned cmds_taken  = 0;
  int unsigned cycle_count = 0;

  gap_crossing_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  gap_crossing_sequencer_checker #(
    .TICK_W (TICK_W)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .in_flight_o  (in_flight),
    .phase_o      (seq_phase)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gap_crossing_sequencer_tb: FAIL");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(logic burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [11:0] surface_reading(logic [11:0] thr);
    if (thr == '0) return 12'($urandom_range(0, 4095));
    case ($urandom_range(0, 7))
      0:       return thr;
      1:       return 12'd1;
      default: return 12'($urandom_range(1, thr));
    endcase
  endfunction

  function automatic logic [11:0] gap_reading(logic [11:0] thr);
    if (thr == 12'hFFF) return '0;
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2:       return thr + 12'd1;
      default: return 12'($urandom_range(int'(thr) + 1, 4095));
    endcase
  endfunction

  // Offer one tick and hold it until the block takes it
  task automatic send_tick(input logic [11:0] d_end, d_rear, d_front, d_start,
                           input logic btn, done, input logic [31:0] stamp);
    int unsigned hold;
    hold = draw_wait(tx_burst);
    if (hold != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TICK_W - TICK_BITS){1'b0}}, stamp, done, btn,
                      d_start, d_front, d_rear, d_end};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
    if (ticks_sent % 32 == 0) tx_burst = ($urandom_range(0, 2) == 0);
  endtask

  // Stop offering ticks and hold until every command has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [gcs_pkg::CFG_DATA_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= gcs_pkg::reg_idx_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (gcs_pkg::reg_idx_e'(i))
        gcs_pkg::REG_GAP_THRESH:
          cfg_mirror.gap_threshold   = vals[i][gcs_pkg::THRESH_W-1:0];
        gcs_pkg::REG_ALIGN_MS:  cfg_mirror.align_stable_ms = vals[i];
        gcs_pkg::REG_LOWER_MS:  cfg_mirror.lower_time_ms   = vals[i];
        gcs_pkg::REG_RAISE_MS:  cfg_mirror.raise_time_ms   = vals[i];
        gcs_pkg::REG_SETTLE_MS: cfg_mirror.settle_time_ms  = vals[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // One full crossing under reset settings, stepping over each boundary
  task automatic run_directed();
    now_ms = '0;
    send_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, now_ms);
    now_ms = NEAR_WRAP;
    send_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b1, now_ms);
    now_ms += 1; send_tick(12'd100, 12'd100, 12'd100, 12'd100, 1'b1, 1'b0, now_ms);
    now_ms += 1; send_tick(12'd100, 12'd100, 12'd100, 12'd100, 1'b0, 1'b0, now_ms);
    // front exactly at the threshold is still surface, one above is a gap
    now_ms += 1; send_tick(12'd100, 12'd100, 12'd250, 12'd100, 1'b0, 1'b0, now_ms);
    now_ms += 1; send_tick(12'd100, 12'd100, 12'd251, 12'd100, 1'b0, 1'b0, now_ms);
    now_ms += 7; send_tick(12'd1, 12'd100, 12'd251, 12'd250, 1'b0, 1'b0, now_ms);
    now_ms += 5; send_tick(12'd0, 12'd100, 12'd251, 12'd250, 1'b0, 1'b0, now_ms);
    now_ms += 5; send_tick(12'd250, 12'd100, 12'd251, 12'd1, 1'b0, 1'b0, now_ms);
    // stable window closes across the timestamp wrap
    now_ms += 499; send_tick(12'd250, 12'd100, 12'd251, 12'd1, 1'b0, 1'b0, now_ms);
    now_ms += 1;   send_tick(12'd250, 12'd100, 12'd251, 12'd1, 1'b0, 1'b0, now_ms);
    now_ms += 2999; send_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, now_ms);
    now_ms += 1;    send_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, now_ms);
    // done on the issuing tick must be ignored
    now_ms += 1; send_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1, now_ms);
    now_ms += 1; send_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, now_ms);
    now_ms += 1; send_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1, now_ms);
    now_ms += 500; send_tick(12'd100, 12'hFFF, 12'd100, 12'd100, 1'b0, 1'b0, now_ms);
    now_ms += 1;   send_tick(12'd100, 12'd100, 12'd100, 12'd100, 1'b0, 1'b0, now_ms);
    now_ms += 2499; send_tick(12'd100, 12'd100, 12'd100, 12'd100, 1'b0, 1'b0, now_ms);
    now_ms += 1;    send_tick(12'd100, 12'd100, 12'd100, 12'd100, 1'b0, 1'b0, now_ms);
    now_ms += 1; send_tick(12'd100, 12'd100, 12'd100, 12'd100, 1'b1, 1'b1, now_ms);
    now_ms += 1; send_tick(12'd100, 12'd100, 12'd100, 12'd100, 1'b0, 1'b1, now_ms);
    now_ms += 1; send_tick(12'd100, 12'd100, 12'd0, 12'd100, 1'b0, 1'b0, now_ms);
  endtask

  // Shape each tick after the phase the sequence is predicted to be in
  task automatic random_tick();
    logic [11:0] thr;
    logic [11:0] dist_mm [4];
    logic        btn, done;
    int unsigned span;
    thr  = cfg_mirror.gap_threshold;
    span = 100;
    foreach (dist_mm[i])
      dist_mm[i] = $urandom_range(0, 1) ? surface_reading(thr) : gap_reading(thr);
    btn  = 1'($urandom_range(0, 1));
    done = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 7) != 0) begin
      case (seq_phase)
        gcs_pkg::CODE_RELEASE: btn = ($urandom_range(0, 2) == 0);
        gcs_pkg::CODE_SEARCH:
          dist_mm[2] = ($urandom_range(0, 3) == 0) ? gap_reading(thr)
                                                   : surface_reading(thr);
        gcs_pkg::CODE_ALIGN: begin
          dist_mm[0] = ($urandom_range(0, 7) != 0) ? surface_reading(thr)
                                                   : gap_reading(thr);
          dist_mm[3] = ($urandom_range(0, 7) != 0) ? surface_reading(thr)
                                                   : gap_reading(thr);
          span       = 32'(cfg_mirror.align_stable_ms);
        end
        gcs_pkg::CODE_LOWER: span = 32'(cfg_mirror.lower_time_ms);
        gcs_pkg::CODE_ACROSS, gcs_pkg::CODE_AHEAD: done = 1'($urandom_range(0, 1));
        gcs_pkg::CODE_SETTLE: begin
          dist_mm[1] = ($urandom_range(0, 3) != 0) ? surface_reading(thr)
                                                   : gap_reading(thr);
          dist_mm[2] = ($urandom_range(0, 3) != 0) ? surface_reading(thr)
                                                   : gap_reading(thr);
          span       = 32'(cfg_mirror.settle_time_ms);
        end
        gcs_pkg::CODE_RAISE: span = 32'(cfg_mirror.raise_time_ms);
        default: ;
      endcase
    end else begin
      foreach (dist_mm[i]) dist_mm[i] = 12'($urandom_range(0, 4095));
    end
    case ($urandom_range(0, 31))
      0:       now_ms = $urandom();
      1:       now_ms += span;
      default: now_ms += $urandom_range(0, span / 2 + 1);
    endcase
    send_tick(dist_mm[0], dist_mm[1], dist_mm[2], dist_mm[3], btn, done, now_ms);
  endtask

  // Result side: stall a random number of cycles before each command
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(rx_burst);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      cmds_taken++;
      if (cmds_taken % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    logic [gcs_pkg::CFG_DATA_W-1:0] vals [8];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int set_no = 0; set_no < SETS; set_no++) begin
      if (set_no == 0) begin
        run_directed();
      end else begin
        drain();
        case (set_no)
          1: foreach (vals[i]) vals[i] = '1;
          2: foreach (vals[i]) vals[i] = '0;
          3: begin
            vals[gcs_pkg::REG_DRIVE_SPEED] = 16'd1000;
            vals[gcs_pkg::REG_GAP_THRESH]  = 16'd1;
            vals[gcs_pkg::REG_LIFT_POWER]  = 16'd1000;
            vals[gcs_pkg::REG_ALIGN_MS]    = 16'($urandom_range(0, 50));
            vals[gcs_pkg::REG_LOWER_MS]    = 16'($urandom_range(0, 50));
            vals[gcs_pkg::REG_RAISE_MS]    = 16'($urandom_range(0, 50));
            vals[gcs_pkg::REG_SETTLE_MS]   = 16'($urandom_range(0, 50));
            vals[gcs_pkg::REG_MOVE_TICKS]  = 16'h7FFF;
          end
          default: begin
            foreach (vals[i])
              vals[i] = $urandom_range(0, 3) ? 16'($urandom_range(0, 400))
                                             : 16'($urandom_range(0, 16'hFFFF));
            vals[gcs_pkg::REG_DRIVE_SPEED] = 16'($urandom_range(0, 1023));
            vals[gcs_pkg::REG_GAP_THRESH]  = 16'($urandom_range(0, 4095));
            vals[gcs_pkg::REG_LIFT_POWER]  = 16'($urandom_range(0, 1023));
            vals[gcs_pkg::REG_MOVE_TICKS]  = 16'($urandom_range(0, 16'h7FFF));
          end
        endcase
        write_regs(vals);
      end
      repeat (TICKS_PER_SET / 2) random_tick();
      drain();
      repeat (TICKS_PER_SET - TICKS_PER_SET / 2) random_tick();
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && in_flight == 0) begin
      $display("gap_crossing_sequencer_tb: PASS");
    end else begin
      $display("gap_crossing_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
